[rtl/core/srlp_pkg.sv]
// ---------------------------------------------------------------------------
// srlp_pkg: shared constants for the sine rainbow LED pattern block
// Strip length, field widths, register addresses and the sine lookup table.
// ---------------------------------------------------------------------------
package srlp_pkg;

   // Strip length, 1..64 LEDs.
   localparam int LED_COUNT = 32;
   localparam int IDX_W     = 6;
   localparam logic [IDX_W-1:0] LED_LAST = IDX_W'(LED_COUNT - 1);

   // Color channel offsets into the sine table, relative to green.
   localparam logic [7:0] RED_OFFSET  = 8'd85;
   localparam logic [7:0] BLUE_OFFSET = 8'd170;

   // Register reset values.
   localparam logic       MODE_RESET = 1'b0;
   localparam logic [7:0] STEP_RESET = 8'd10;

   // Configuration port.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   typedef enum logic {
      REG_PATTERN_MODE = 1'b0,
      REG_PHASE_STEP   = 1'b1
   } reg_index_type;

   // Pattern mode codes.
   localparam logic MODE_MARQUEE = 1'b0;
   localparam logic MODE_BREATH  = 1'b1;

   // One full period of a sine centered on 128.
   localparam logic [7:0] SINE_ROM [256] = '{
      8'd128, 8'd131, 8'd134, 8'd137, 8'd140, 8'd143, 8'd147, 8'd150, 8'd153, 8'd156,
      8'd159, 8'd162, 8'd165, 8'd168, 8'd171, 8'd174, 8'd177, 8'd180, 8'd182, 8'd185,
      8'd188, 8'd191, 8'd194, 8'd196, 8'd199, 8'd201, 8'd204, 8'd206, 8'd209, 8'd211,
      8'd214, 8'd216, 8'd218, 8'd220, 8'd223, 8'd225, 8'd227, 8'd229, 8'd230, 8'd232,
      8'd234, 8'd236, 8'd237, 8'd239, 8'd240, 8'd242, 8'd243, 8'd245, 8'd246, 8'd247,
      8'd248, 8'd249, 8'd250, 8'd251, 8'd252, 8'd252, 8'd253, 8'd253, 8'd254, 8'd254,
      8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd254,
      8'd254, 8'd253, 8'd253, 8'd252, 8'd251, 8'd250, 8'd249, 8'd249, 8'd247, 8'd246,
      8'd245, 8'd244, 8'd243, 8'd241, 8'd240, 8'd238, 8'd237, 8'd235, 8'd233, 8'd231,
      8'd229, 8'd228, 8'd226, 8'd224, 8'd221, 8'd219, 8'd217, 8'd215, 8'd212, 8'd210,
      8'd208, 8'd205, 8'd203, 8'd200, 8'd198, 8'd195, 8'd192, 8'd189, 8'd187, 8'd184,
      8'd181, 8'd178, 8'd175, 8'd172, 8'd169, 8'd166, 8'd163, 8'd160, 8'd157, 8'd154,
      8'd151, 8'd148, 8'd145, 8'd142, 8'd139, 8'd136, 8'd132, 8'd129, 8'd126, 8'd123,
      8'd120, 8'd117, 8'd114, 8'd111, 8'd107, 8'd104, 8'd101, 8'd98,  8'd95,  8'd92,
      8'd89,  8'd86,  8'd83,  8'd80,  8'd77,  8'd74,  8'd72,  8'd69,  8'd66,  8'd63,
      8'd61,  8'd58,  8'd55,  8'd53,  8'd50,  8'd48,  8'd45,  8'd43,  8'd41,  8'd38,
      8'd36,  8'd34,  8'd32,  8'd30,  8'd28,  8'd26,  8'd24,  8'd22,  8'd21,  8'd19,
      8'd17,  8'd16,  8'd14,  8'd13,  8'd12,  8'd10,  8'd9,   8'd8,   8'd7,   8'd6,
      8'd5,   8'd4,   8'd4,   8'd3,   8'd2,   8'd2,   8'd1,   8'd1,   8'd1,   8'd0,
      8'd0,   8'd0,   8'd0,   8'd0,   8'd1,   8'd1,   8'd1,   8'd2,   8'd2,   8'd3,
      8'd3,   8'd4,   8'd5,   8'd6,   8'd6,   8'd7,   8'd9,   8'd10,  8'd11,  8'd12,
      8'd14,  8'd15,  8'd17,  8'd18,  8'd20,  8'd21,  8'd23,  8'd25,  8'd27,  8'd29,
      8'd31,  8'd33,  8'd35,  8'd37,  8'd40,  8'd42,  8'd44,  8'd47,  8'd49,  8'd52,
      8'd54,  8'd57,  8'd59,  8'd62,  8'd65,  8'd67,  8'd70,  8'd73,  8'd76,  8'd79,
      8'd82,  8'd85,  8'd88,  8'd91,  8'd94,  8'd97,  8'd100, 8'd103, 8'd106, 8'd109,
      8'd112, 8'd115, 8'd118, 8'd121, 8'd125, 8'd128
   };

endpackage

[rtl/core/sine_rainbow_led_pattern.sv]
// ---------------------------------------------------------------------------
// sine_rainbow_led_pattern: rainbow animation frames from a sine table
// Turns each frame tick into one pixel item per LED of the strip.
// ---------------------------------------------------------------------------
// Usage:
//   The req channel carries frame ticks. A tick item with frame_tick set
//   renders one frame: the rsp channel then carries LED_COUNT pixel items,
//   led_index 0 first, with last_led set on the final one. A tick item with
//   frame_tick clear is taken and dropped.
//   A taken tick loads the walker; the output register then takes pixel 0.
//   Throughput: one pixel per cycle while rsp_stall is low; the pixel walker
//   is busy for the whole frame and holds req_stall meanwhile. The
//   next tick is taken in the cycle the last pixel leaves the walker, so
//   frames follow each other with no gap.
//   The walker adds phase_step to the green table index once per pixel,
//   or zero in breath mode; the three table reads and output register follow.
//   When rsp_stall is high the output register holds its pixel and the
//   walker waits; nothing is lost.
//   Reset clears the phase to zero, selects marquee mode, sets phase_step
//   to 10 and empties the pipeline. The user must write registers over the
//   csr port only while no frame is in flight; the block does not enforce it.
// ---------------------------------------------------------------------------
module sine_rainbow_led_pattern (
   input  logic                                 clock,
   input  logic                                 reset,
   // Frame tick channel.
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_frame_tick,
   // Pixel channel.
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [srlp_pkg::IDX_W-1:0]           rsp_led_index,
   output logic [7:0]                           rsp_red,
   output logic [7:0]                           rsp_green,
   output logic [7:0]                           rsp_blue,
   output logic                                 rsp_last_led,
   // Register port.
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [srlp_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [srlp_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [srlp_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);

   // Configuration registers.
   logic                          mode_ff;
   logic [7:0]                    step_ff;
   logic                          csr_write;
   srlp_pkg::reg_index_type       csr_index;

   // Frame state and pixel walker.
   logic [7:0]                    phase_ff, phase_in;
   logic                          gen_active_ff, gen_active_in;
   logic [srlp_pkg::IDX_W-1:0]    gen_idx_ff, gen_idx_in;
   logic [7:0]                    gen_green_ff, gen_green_in;
   logic [7:0]                    stride;
   logic                          gen_last;
   logic                          req_accept;
   logic                          tick_start;

   // Output register.
   logic                          out_advance;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [srlp_pkg::IDX_W-1:0]    rsp_idx_ff;
   logic [7:0]                    rsp_red_ff, rsp_green_ff, rsp_blue_ff;
   logic                          rsp_last_ff;

   // Register port decode; pready is always high.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = srlp_pkg::reg_index_type'(csr_paddr[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= srlp_pkg::MODE_RESET;
         step_ff <= srlp_pkg::STEP_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            srlp_pkg::REG_PATTERN_MODE: mode_ff <= csr_pwdata[0];
            srlp_pkg::REG_PHASE_STEP:   step_ff <= csr_pwdata[7:0];
            default:                    mode_ff <= mode_ff;
         endcase
      end
   end

   // Register read back.
   always_comb begin
      unique case (csr_index)
         srlp_pkg::REG_PATTERN_MODE: csr_prdata = {{(srlp_pkg::CSR_DATA_W-1){1'b0}}, mode_ff};
         srlp_pkg::REG_PHASE_STEP:   csr_prdata = {{(srlp_pkg::CSR_DATA_W-8){1'b0}}, step_ff};
         default:                    csr_prdata = '0;
      endcase
   end

   // The output register moves when it is empty or its item is taken.
   assign out_advance = !rsp_valid_ff || !rsp_stall;
   assign gen_last    = (gen_idx_ff == srlp_pkg::LED_LAST);

   // A tick is taken when the walker is idle or hands off its last pixel.
   assign req_stall  = gen_active_ff && !(gen_last && out_advance);
   assign req_accept = req_valid && !req_stall;
   assign tick_start = req_accept && req_frame_tick;

   // Breath mode gives every LED the same table index.
   assign stride = (mode_ff == srlp_pkg::MODE_BREATH) ? 8'd0 : step_ff;

   // Walker next state: start a frame, step to the next LED, or finish.
   always_comb begin
      phase_in      = phase_ff;
      gen_active_in = gen_active_ff;
      gen_idx_in    = gen_idx_ff;
      gen_green_in  = gen_green_ff;
      if (tick_start) begin
         phase_in      = phase_ff + 8'd1;
         gen_active_in = 1'b1;
         gen_idx_in    = '0;
         gen_green_in  = phase_ff;
      end else if (gen_active_ff && out_advance) begin
         if (gen_last) begin
            gen_active_in = 1'b0;
         end else begin
            gen_idx_in   = gen_idx_ff + 1'b1;
            gen_green_in = gen_green_ff + stride;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= '0;
         gen_active_ff <= 1'b0;
         gen_idx_ff    <= '0;
      end else begin
         phase_ff      <= phase_in;
         gen_active_ff <= gen_active_in;
         gen_idx_ff    <= gen_idx_in;
      end
      gen_green_ff <= gen_green_in;
   end

   // Table lookups into the output register.
   assign rsp_valid_in = out_advance ? gen_active_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (out_advance && gen_active_ff) begin
         rsp_idx_ff   <= gen_idx_ff;
         rsp_green_ff <= srlp_pkg::SINE_ROM[gen_green_ff];
         rsp_red_ff   <= srlp_pkg::SINE_ROM[gen_green_ff + srlp_pkg::RED_OFFSET];
         rsp_blue_ff  <= srlp_pkg::SINE_ROM[gen_green_ff + srlp_pkg::BLUE_OFFSET];
         rsp_last_ff  <= gen_last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_led_index = rsp_idx_ff;
   assign rsp_red       = rsp_red_ff;
   assign rsp_green     = rsp_green_ff;
   assign rsp_blue      = rsp_blue_ff;
   assign rsp_last_led  = rsp_last_ff;

   // Within a frame the pixels follow each other without a gap.
   a_index_steps: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_last_led) |=>
         (rsp_valid && rsp_led_index == $past(rsp_led_index) + 1'b1))
      else $error("pixel sequence broken within a frame");

   // The last LED flag marks exactly the final index.
   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_led == (rsp_led_index == srlp_pkg::LED_LAST)))
      else $error("last_led does not match led_index");

   // A rendering tick starts the walker at LED zero and advances the phase.
   a_frame_start: assert property (@(posedge clock) disable iff (reset)
      tick_start |=> (gen_active_ff && gen_idx_ff == '0 &&
                      phase_ff == $past(phase_ff) + 8'd1))
      else $error("frame start did not load the walker");

   // Ticks are only held back while a frame is being walked.
   a_stall_busy: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> gen_active_ff)
      else $error("tick stalled with idle walker");

endmodule

[tb/sv/sine_rainbow_led_pattern_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sine_rainbow_led_pattern_tb: frame and pixel checks for the rainbow block
// Sends frame ticks in random bursts, stalls the pixel channel on a changing
// pattern and compares every pixel with a frame predictor kept in the bench.
// Mode and step are rewritten between phases while the block is idle.
// ---------------------------------------------------------------------------
module sine_rainbow_led_pattern_tb;

   localparam int FRAMES_TO_RUN = 430;
   localparam int SETTLE_CYCLES = 2 * srlp_pkg::LED_COUNT;

   // Channel offsets relative to the green table index.
   localparam logic [7:0] GREEN_TO_RED  = 8'd85;
   localparam logic [7:0] GREEN_TO_BLUE = 8'd170;
   localparam logic [7:0] STEP_AT_RESET = 8'd10;

   // Full sine period, 0..255 centered on 128.
   localparam logic [7:0] SINE_LEVEL [256] = '{
      8'd128, 8'd131, 8'd134, 8'd137, 8'd140, 8'd143, 8'd147, 8'd150, 8'd153, 8'd156,
      8'd159, 8'd162, 8'd165, 8'd168, 8'd171, 8'd174, 8'd177, 8'd180, 8'd182, 8'd185,
      8'd188, 8'd191, 8'd194, 8'd196, 8'd199, 8'd201, 8'd204, 8'd206, 8'd209, 8'd211,
      8'd214, 8'd216, 8'd218, 8'd220, 8'd223, 8'd225, 8'd227, 8'd229, 8'd230, 8'd232,
      8'd234, 8'd236, 8'd237, 8'd239, 8'd240, 8'd242, 8'd243, 8'd245, 8'd246, 8'd247,
      8'd248, 8'd249, 8'd250, 8'd251, 8'd252, 8'd252, 8'd253, 8'd253, 8'd254, 8'd254,
      8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd254,
      8'd254, 8'd253, 8'd253, 8'd252, 8'd251, 8'd250, 8'd249, 8'd249, 8'd247, 8'd246,
      8'd245, 8'd244, 8'd243, 8'd241, 8'd240, 8'd238, 8'd237, 8'd235, 8'd233, 8'd231,
      8'd229, 8'd228, 8'd226, 8'd224, 8'd221, 8'd219, 8'd217, 8'd215, 8'd212, 8'd210,
      8'd208, 8'd205, 8'd203, 8'd200, 8'd198, 8'd195, 8'd192, 8'd189, 8'd187, 8'd184,
      8'd181, 8'd178, 8'd175, 8'd172, 8'd169, 8'd166, 8'd163, 8'd160, 8'd157, 8'd154,
      8'd151, 8'd148, 8'd145, 8'd142, 8'd139, 8'd136, 8'd132, 8'd129, 8'd126, 8'd123,
      8'd120, 8'd117, 8'd114, 8'd111, 8'd107, 8'd104, 8'd101, 8'd98,  8'd95,  8'd92,
      8'd89,  8'd86,  8'd83,  8'd80,  8'd77,  8'd74,  8'd72,  8'd69,  8'd66,  8'd63,
      8'd61,  8'd58,  8'd55,  8'd53,  8'd50,  8'd48,  8'd45,  8'd43,  8'd41,  8'd38,
      8'd36,  8'd34,  8'd32,  8'd30,  8'd28,  8'd26,  8'd24,  8'd22,  8'd21,  8'd19,
      8'd17,  8'd16,  8'd14,  8'd13,  8'd12,  8'd10,  8'd9,   8'd8,   8'd7,   8'd6,
      8'd5,   8'd4,   8'd4,   8'd3,   8'd2,   8'd2,   8'd1,   8'd1,   8'd1,   8'd0,
      8'd0,   8'd0,   8'd0,   8'd0,   8'd1,   8'd1,   8'd1,   8'd2,   8'd2,   8'd3,
      8'd3,   8'd4,   8'd5,   8'd6,   8'd6,   8'd7,   8'd9,   8'd10,  8'd11,  8'd12,
      8'd14,  8'd15,  8'd17,  8'd18,  8'd20,  8'd21,  8'd23,  8'd25,  8'd27,  8'd29,
      8'd31,  8'd33,  8'd35,  8'd37,  8'd40,  8'd42,  8'd44,  8'd47,  8'd49,  8'd52,
      8'd54,  8'd57,  8'd59,  8'd62,  8'd65,  8'd67,  8'd70,  8'd73,  8'd76,  8'd79,
      8'd82,  8'd85,  8'd88,  8'd91,  8'd94,  8'd97,  8'd100, 8'd103, 8'd106, 8'd109,
      8'd112, 8'd115, 8'd118, 8'd121, 8'd125, 8'd128
   };

   typedef struct packed {
      logic [srlp_pkg::IDX_W-1:0] led_index;
      logic [7:0]                 red;
      logic [7:0]                 green;
      logic [7:0]                 blue;
      logic                       last_led;
   } pixel_type;

   typedef enum int {
      STALL_NONE,
      STALL_RANDOM,
      STALL_BURST
   } stall_style_type;

   // Frame predictor and the queue of pixels still owed by the block.
   class frame_scoreboard;
      pixel_type  expected_pixels[$];
      logic       strip_mode;
      logic [7:0] led_step;
      logic [7:0] frame_phase;
      int         errors;

      function new();
         strip_mode  = srlp_pkg::MODE_MARQUEE;
         led_step    = STEP_AT_RESET;
         frame_phase = 8'd0;
         errors      = 0;
      endfunction

      function void set_register(srlp_pkg::reg_index_type which, logic [31:0] value);
         if (which == srlp_pkg::REG_PATTERN_MODE) begin
            strip_mode = value[0];
         end else begin
            led_step = value[7:0];
         end
      endfunction

      function int pending();
         return expected_pixels.size();
      endfunction

      // An accepted tick with the bit set renders one frame and moves the phase.
      function void note_tick(logic tick);
         pixel_type  pix;
         logic [7:0] green_at;
         logic [7:0] offset;
         if (!tick) begin
            return;
         end
         for (int j = 0; j < srlp_pkg::LED_COUNT; j++) begin
            offset = (strip_mode == srlp_pkg::MODE_BREATH) ? 8'd0 :
                     8'(int'(led_step) * j);
            green_at = frame_phase + offset;
            pix.led_index = srlp_pkg::IDX_W'(j);
            pix.red       = SINE_LEVEL[8'(green_at + GREEN_TO_RED)];
            pix.green     = SINE_LEVEL[green_at];
            pix.blue      = SINE_LEVEL[8'(green_at + GREEN_TO_BLUE)];
            pix.last_led  = (j == srlp_pkg::LED_COUNT - 1);
            expected_pixels.push_back(pix);
         end
         frame_phase = frame_phase + 8'd1;
      endfunction

      function void compare_field(string field, int want, int got);
         if (want != got) begin
            errors++;
            $display("%0t ns: pixel mismatch on %s, expected %0d, actual %0d",
                     $time, field, want, got);
         end
      endfunction

      function void check_pixel(pixel_type got);
         pixel_type want;
         if (expected_pixels.size() == 0) begin
            errors++;
            $display("%0t ns: unexpected pixel, expected none, actual led %0d",
                     $time, got.led_index);
            return;
         end
         want = expected_pixels.pop_front();
         compare_field("led_index", want.led_index, got.led_index);
         compare_field("red", want.red, got.red);
         compare_field("green", want.green, got.green);
         compare_field("blue", want.blue, got.blue);
         compare_field("last_led", want.last_led, got.last_led);
      endfunction
   endclass

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   logic                            req_frame_tick = 1'b0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   logic [srlp_pkg::IDX_W-1:0]      rsp_led_index;
   logic [7:0]                      rsp_red;
   logic [7:0]                      rsp_green;
   logic [7:0]                      rsp_blue;
   logic                            rsp_last_led;
   logic                            csr_psel = 1'b0;
   logic                            csr_penable = 1'b0;
   logic                            csr_pwrite = 1'b0;
   logic [srlp_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [srlp_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [srlp_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                            csr_pready;

   frame_scoreboard sb = new();
   int              frames_sent = 0;

   sine_rainbow_led_pattern uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_frame_tick (req_frame_tick),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_led_index  (rsp_led_index),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue),
      .rsp_last_led   (rsp_last_led),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   always #1 clock = ~clock;

   // Pixel receiver: checks accepted pixels, then picks the next stall value.
   stall_style_type stall_style = STALL_NONE;
   int              style_left = 0;
   int              burst_left = 0;
   bit              burst_on = 1'b0;

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         sb.check_pixel('{rsp_led_index, rsp_red, rsp_green, rsp_blue, rsp_last_led});
      end
      if (style_left == 0) begin
         style_left  = $urandom_range(40, 300);
         stall_style = stall_style_type'($urandom_range(0, 2));
      end else begin
         style_left--;
      end
      case (stall_style)
         STALL_NONE: begin
            rsp_stall <= 1'b0;
         end
         STALL_RANDOM: begin
            rsp_stall <= ($urandom_range(0, 2) == 0);
         end
         default: begin
            if (burst_left == 0) begin
               burst_on   = !burst_on;
               burst_left = $urandom_range(1, 8);
            end
            burst_left--;
            rsp_stall <= burst_on;
         end
      endcase
   end

   // Offers one tick item and returns at the edge where it is taken.
   task automatic send_item(logic tick);
      req_valid      <= 1'b1;
      req_frame_tick <= tick;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      sb.note_tick(tick);
      if (tick) begin
         frames_sent++;
      end
   endtask

   // Sends a number of frames in bursts, with a few ignored ticks mixed in.
   task automatic send_frames(int frames);
      int left;
      int burst;
      int gap;
      left = frames;
      while (left > 0) begin
         burst = $urandom_range(1, 10);
         while (burst > 0 && left > 0) begin
            if ($urandom_range(0, 11) == 0) begin
               send_item(1'b0);
            end else begin
               send_item(1'b1);
               left--;
            end
            burst--;
         end
         gap = $urandom_range(0, 40);
         if (gap > 0) begin
            req_valid      <= 1'b0;
            req_frame_tick <= 1'($urandom);
            repeat (gap) @(posedge clock);
         end
      end
      req_valid <= 1'b0;
   endtask

   // Waits until all pixels are out and any ignored tick has drained.
   task automatic wait_idle();
      while (sb.pending() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register write: setup cycle, then access cycle until pready.
   task automatic csr_write(srlp_pkg::reg_index_type which, logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= srlp_pkg::CSR_ADDR_W'(int'(which) * 4);
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) begin
         @(posedge clock);
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      sb.set_register(which, value);
      @(posedge clock);
   endtask

   // Writes both registers; the unused upper bits carry random junk.
   task automatic configure(logic mode, logic [7:0] step);
      logic [31:0] value;
      wait_idle();
      value    = $urandom;
      value[0] = mode;
      csr_write(srlp_pkg::REG_PATTERN_MODE, value);
      value      = $urandom;
      value[7:0] = step;
      csr_write(srlp_pkg::REG_PHASE_STEP, value);
   endtask

   task automatic send_single(logic tick);
      send_item(tick);
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      logic       mode;
      logic [7:0] step;
      int         phase_frames;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: default step, an ignored tick between frames.
      send_single(1'b1);
      send_single(1'b0);
      send_item(1'b1);
      send_item(1'b0);
      send_single(1'b1);

      // Step extremes in marquee mode.
      configure(srlp_pkg::MODE_MARQUEE, 8'd0);
      send_frames(2);
      configure(srlp_pkg::MODE_MARQUEE, 8'd255);
      send_frames(2);
      configure(srlp_pkg::MODE_MARQUEE, 8'd1);
      send_frames(2);

      // Breath mode ignores the step entirely; then marquee mode with a step of 128.
      configure(srlp_pkg::MODE_BREATH, 8'd200);
      send_frames(2);
      configure(srlp_pkg::MODE_BREATH, 8'd0);
      send_frames(2);
      configure(srlp_pkg::MODE_MARQUEE, 8'd128);
      send_frames(2);

      // Random phases, each with its own settings; the phase wraps along the way.
      while (frames_sent < FRAMES_TO_RUN) begin
         mode = ($urandom_range(0, 3) == 0) ? srlp_pkg::MODE_BREATH :
                srlp_pkg::MODE_MARQUEE;
         case ($urandom_range(0, 5))
            0: begin
               step = 8'd0;
            end
            1: begin
               step = 8'd255;
            end
            2: begin
               step = 8'($urandom_range(1, 3));
            end
            default: begin
               step = 8'($urandom);
            end
         endcase
         configure(mode, step);
         phase_frames = $urandom_range(10, 60);
         if (phase_frames > FRAMES_TO_RUN - frames_sent) begin
            phase_frames = FRAMES_TO_RUN - frames_sent;
         end
         send_frames(phase_frames);
      end

      wait_idle();
      if (sb.errors == 0) begin
         $display("[sine_rainbow_led_pattern] OK");
      end else begin
         $display("[sine_rainbow_led_pattern] ERROR");
      end
      $finish;
   end

   // Watchdog well beyond the slowest legal run.
   initial begin
      #2000000;
      $display("[sine_rainbow_led_pattern] ERROR");
      $finish;
   end

endmodule
